// ===== hdl/console_line_editor_macros.svh =====
// ============================================================================
// Console line editor assertion macros
// Shared property shorthands for the checker. Each macro expects signals
// named clk and arst_n in the scope where it is used.
// ============================================================================
`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("console line editor check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("console line editor check failed");

`endif

// ===== hdl/cle_pkg.sv =====
// ============================================================================
// Console line editor package
// Types, event codes and control characters shared by the editor files.
// ============================================================================
package cle_pkg;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;

	localparam logic [1:0] EV_NONE     = 2'd0;
	localparam logic [1:0] EV_COMPLETE = 2'd1;
	localparam logic [1:0] EV_OVERFLOW = 2'd2;
	localparam logic [1:0] EV_READ     = 2'd3;

	localparam logic ACT_RECEIVE = 1'b0;
	localparam logic ACT_READ    = 1'b1;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_THIRD  = 2'd2;

	typedef enum logic [2:0] {
		KIND_READ,
		KIND_END,
		KIND_BS,
		KIND_CHAR,
		KIND_NOP
	} kind_t;

endpackage

// ===== hdl/cle_in_if.sv =====
// ============================================================================
// Console line editor command channel
// Carries one received byte or one line store read request per beat.
// ============================================================================
interface cle_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;
	logic [6:0] read_index;

	modport source (output valid, output action, output rx_byte, output read_index,
		input ready);
	modport sink (input valid, input action, input rx_byte, input read_index,
		output ready);
endinterface

// ===== hdl/cle_out_if.sv =====
// ============================================================================
// Console line editor result channel
// Carries one echo, event or read result per beat.
// ============================================================================
interface cle_out_if;
	logic       valid;
	logic       ready;
	logic       echo_valid;
	logic [7:0] echo_byte;
	logic [1:0] event_res;
	logic [6:0] entry_length;
	logic [7:0] read_byte;
	logic       last;

	modport source (output valid, output echo_valid, output echo_byte, output event_res,
		output entry_length, output read_byte, output last, input ready);
	modport sink (input valid, input echo_valid, input echo_byte, input event_res,
		input entry_length, input read_byte, input last, output ready);
endinterface

// ===== hdl/cle_cfg_if.sv =====
// ============================================================================
// Console line editor configuration channel
// Carries the word mode bit; each beat writes the register.
// ============================================================================
interface cle_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cle_ram.sv =====
// ============================================================================
// Console line editor generic RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/console_line_editor.sv =====
// ============================================================================
// Console line editor
// Assembles received console bytes into a line store with echo, backspace
// editing, entry completion and overflow reporting, and serves reads of it.
// ============================================================================
//
//  Channel  Role    Beat contents
//  -------  ------  ---------------------------------------------------------
//  cmd      sink    action, rx_byte, read_index
//  res      source  echo_valid, echo_byte, event_res, entry_length,
//                   read_byte, last
//  cfg      sink    word mode bit, always ready
//
// A command passes an input register and a result register, so its first
// result beat is offered from the result register. A backspace yields
// three result beats and holds the result register until the last is
// taken; every other command yields one beat, and a new command can be
// taken each cycle while the result register is not stalled. A backspace
// on an empty line yields no beat. Reset empties both stages and the line;
// no clearing pass is needed. A stalled result register stalls the input
// register, which then drops cmd.ready.
module console_line_editor #(
	parameter int LINE_LEN = 64
) (
	input  logic clk,
	input  logic arst_n,
	cle_in_if.sink    cmd,
	cle_out_if.source res,
	cle_cfg_if.sink   cfg
);

	localparam int FW = $clog2(LINE_LEN);
	localparam int AW = $clog2(LINE_LEN + 1);
	localparam int CW = (AW > 7) ? AW : 7;
	localparam logic [CW-1:0] LINE_LEN_W = CW'(LINE_LEN);
	localparam logic [FW-1:0] FILL_TOP = FW'(LINE_LEN - 1);

	logic word_mode_q;

	logic       v_s1;
	logic       action_s1;
	logic [7:0] byte_s1;
	logic [6:0] idx_s1;

	logic [FW-1:0] fill_q;
	logic [AW-1:0] hw_q;

	logic             v_s2;
	cle_pkg::kind_t   kind_s2;
	logic [7:0]       byte_s2;
	logic [1:0]       ev_s2;
	logic [6:0]       len_s2;
	logic             inr_s2;
	logic [1:0]       pos_q;

	cle_pkg::kind_t kind;
	logic           ends;
	logic           produces;
	logic           last_now;
	logic           s2_free;
	logic           adv1;
	logic           load2;
	logic [CW-1:0]  fill_ext;
	logic [CW-1:0]  idx_ext;
	logic           in_range;
	logic [1:0]     ev_new;
	logic [6:0]     len_new;
	logic           wrap;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			word_mode_q <= cfg.data;
		end
	end

	// Input stage.
	assign cmd.ready = !v_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1 <= cmd.action;
			byte_s1   <= cmd.rx_byte;
			idx_s1    <= cmd.read_index;
		end
	end

	// Decode of the held command against the line state.
	assign fill_ext = CW'(fill_q);
	assign idx_ext  = CW'(idx_s1);
	assign in_range = idx_ext < CW'(hw_q);
	assign wrap     = fill_q == FILL_TOP;

	always_comb begin
		ends = (byte_s1 == cle_pkg::CH_CR) || (byte_s1 == cle_pkg::CH_LF) ||
			(word_mode_q && ((byte_s1 == cle_pkg::CH_TAB) || (byte_s1 == cle_pkg::CH_SPACE)));
		priority if (action_s1 == cle_pkg::ACT_READ) begin
			kind = cle_pkg::KIND_READ;
		end else if (ends) begin
			kind = cle_pkg::KIND_END;
		end else if (byte_s1 == cle_pkg::CH_BS) begin
			kind = (fill_q == '0) ? cle_pkg::KIND_NOP : cle_pkg::KIND_BS;
		end else begin
			kind = cle_pkg::KIND_CHAR;
		end
		produces = kind != cle_pkg::KIND_NOP;

		ev_new  = cle_pkg::EV_NONE;
		len_new = '0;
		unique case (kind)
			cle_pkg::KIND_READ: begin
				ev_new = cle_pkg::EV_READ;
			end
			cle_pkg::KIND_END: begin
				ev_new  = cle_pkg::EV_COMPLETE;
				len_new = fill_ext[6:0];
			end
			cle_pkg::KIND_CHAR: begin
				if (wrap) begin
					ev_new  = cle_pkg::EV_OVERFLOW;
					len_new = LINE_LEN_W[6:0];
				end
			end
			default: begin
				ev_new = cle_pkg::EV_NONE;
			end
		endcase
	end

	assign last_now = (kind_s2 != cle_pkg::KIND_BS) || (pos_q == cle_pkg::POS_THIRD);
	assign s2_free  = !v_s2 || (res.ready && last_now);
	assign adv1     = v_s1 && (!produces || s2_free);
	assign load2    = adv1 && produces;

	// Line state and store writes.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(fill_q);
		ram_wdata = '0;
		if (adv1) begin
			unique case (kind)
				cle_pkg::KIND_END: begin
					ram_we = 1'b1;
				end
				cle_pkg::KIND_BS: begin
					ram_we    = 1'b1;
					ram_waddr = AW'(fill_q - FW'(1));
				end
				cle_pkg::KIND_CHAR: begin
					ram_we    = 1'b1;
					ram_wdata = byte_s1;
				end
				default: begin
					ram_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hw_q   <= '0;
		end else if (adv1) begin
			if ((kind == cle_pkg::KIND_END || kind == cle_pkg::KIND_CHAR) &&
				(AW'(fill_q) == hw_q)) begin
				hw_q <= hw_q + AW'(1);
			end
			unique case (kind)
				cle_pkg::KIND_END: begin
					fill_q <= '0;
				end
				cle_pkg::KIND_BS: begin
					fill_q <= fill_q - FW'(1);
				end
				cle_pkg::KIND_CHAR: begin
					fill_q <= wrap ? '0 : fill_q + FW'(1);
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

	cle_ram #(
		.WIDTH(8),
		.DEPTH(LINE_LEN + 1)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (load2 && (kind == cle_pkg::KIND_READ)),
		.raddr (idx_ext[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			pos_q <= cle_pkg::POS_FIRST;
		end else if (load2) begin
			v_s2  <= 1'b1;
			pos_q <= cle_pkg::POS_FIRST;
		end else if (v_s2 && res.ready) begin
			if (last_now) begin
				v_s2  <= 1'b0;
				pos_q <= cle_pkg::POS_FIRST;
			end else begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			kind_s2 <= kind;
			byte_s2 <= byte_s1;
			ev_s2   <= ev_new;
			len_s2  <= len_new;
			inr_s2  <= in_range;
		end
	end

	always_comb begin
		res.valid        = v_s2;
		res.echo_valid   = 1'b1;
		res.echo_byte    = byte_s2;
		res.event_res    = ev_s2;
		res.entry_length = len_s2;
		res.read_byte    = '0;
		res.last         = last_now;
		unique case (kind_s2)
			cle_pkg::KIND_READ: begin
				res.echo_valid = 1'b0;
				res.echo_byte  = '0;
				res.read_byte  = inr_s2 ? ram_rdata : 8'h00;
			end
			cle_pkg::KIND_BS: begin
				res.echo_byte = (pos_q == cle_pkg::POS_SECOND) ? cle_pkg::CH_SPACE
					: cle_pkg::CH_BS;
			end
			default: begin
				res.echo_byte = byte_s2;
			end
		endcase
	end

endmodule

// ===== hdl/cle_checker.sv =====
// ============================================================================
// Console line editor port checker
// Watches the top level's ports for consistency of the result beats.
// ============================================================================
`include "console_line_editor_macros.svh"

module cle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_echo_valid,
	input logic [7:0] res_echo_byte,
	input logic [1:0] res_event,
	input logic [6:0] res_length,
	input logic [7:0] res_read_byte,
	input logic       res_last
);

	logic beat_read;
	logic beat_no_length;
	logic beat_echo;
	logic beat_mid_erase;
	logic erase_echo;

	assign beat_read      = res_valid && (res_event == cle_pkg::EV_READ);
	assign beat_no_length = res_valid &&
		((res_event == cle_pkg::EV_NONE) || (res_event == cle_pkg::EV_READ));
	assign beat_echo      = res_valid && res_echo_valid;
	assign beat_mid_erase = res_valid && res_ready && !res_last;
	assign erase_echo     = res_valid && res_echo_valid &&
		((res_echo_byte == cle_pkg::CH_SPACE) || (res_echo_byte == cle_pkg::CH_BS));

	`CLE_ASSERT_SAME(a_read_alone, beat_read, res_last && !res_echo_valid)
	`CLE_ASSERT_SAME(a_length_only_on_end, beat_no_length, res_length == 7'd0)
	`CLE_ASSERT_SAME(a_echo_beats_no_data, beat_echo, res_read_byte == 8'h00)
	`CLE_ASSERT_NEXT(a_erase_sequence, beat_mid_erase, erase_echo)

endmodule

bind console_line_editor cle_checker u_cle_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_echo_valid (res.echo_valid),
	.res_echo_byte  (res.echo_byte),
	.res_event      (res.event_res),
	.res_length     (res.entry_length),
	.res_read_byte  (res.read_byte),
	.res_last       (res.last)
);
